// ===== hw/rtl/bdsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdsr_pkg: shared types and constants for the boost duty step regulator
// Setpoint levels, register indexes and the fixed voltage scale constants.
// ----------------------------------------------------------------------------
package bdsr_pkg;

   // output voltage setpoint levels
   typedef enum logic [1:0] {
      LEVEL_5V0  = 2'd0,
      LEVEL_5V5  = 2'd1,
      LEVEL_8V0  = 2'd2,
      LEVEL_11V0 = 2'd3
   } setpoint_level_type;

   localparam int unsigned CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REQUEST_HIGH = 2'd0,
      CSR_REQUEST_LOW  = 2'd1
   } csr_index_type;

   // setpoint of each level in mV, indexed by setpoint_level_type
   localparam int unsigned SETPOINT_MV [4] = '{5000, 5500, 8000, 11000};

   // adc full scale: 4.34 V reference times the 5:1 divider, in mV
   localparam int unsigned FULL_SCALE_MV = 21700;
   // headroom added to the setpoint in the duty limit
   localparam int unsigned HEADROOM_MV   = 700;
   // all the mV figures above share this factor
   localparam int unsigned MV_UNIT       = 100;
   // led lights above this setpoint
   localparam int unsigned LED_ON_MV     = 6000;

   localparam int unsigned REQUEST_HIGH_RESET = 500;
   localparam int unsigned REQUEST_LOW_RESET  = 300;

endpackage

// ===== hw/rtl/bdsr_limit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdsr_limit: duty ceiling from the input voltage
// limit = steps - ceil(vin * full_scale * steps / (counts * (setpoint + 700)))
// saturated to 0..steps-1, the quotient taken by reciprocal multiplication.
// ----------------------------------------------------------------------------
module bdsr_limit #(
   parameter int unsigned ADC_COUNTS = 1024,
   parameter int unsigned DUTY_STEPS = 256,
   localparam int unsigned SAMPLE_W = $clog2(ADC_COUNTS),
   localparam int unsigned DUTY_W   = $clog2(DUTY_STEPS)
) (
   input  logic [SAMPLE_W-1:0]          vin,
   input  bdsr_pkg::setpoint_level_type setpoint_level,
   output logic [DUTY_W-1:0]            limit
);

   // numerator and per-level denominators, common mV factor taken out
   localparam longint unsigned NUM = longint'(bdsr_pkg::FULL_SCALE_MV) * DUTY_STEPS
                                     / bdsr_pkg::MV_UNIT;
   localparam longint unsigned DEN_0 = longint'(ADC_COUNTS)
      * (bdsr_pkg::SETPOINT_MV[bdsr_pkg::LEVEL_5V0] + bdsr_pkg::HEADROOM_MV)
      / bdsr_pkg::MV_UNIT;
   localparam longint unsigned DEN_1 = longint'(ADC_COUNTS)
      * (bdsr_pkg::SETPOINT_MV[bdsr_pkg::LEVEL_5V5] + bdsr_pkg::HEADROOM_MV)
      / bdsr_pkg::MV_UNIT;
   localparam longint unsigned DEN_2 = longint'(ADC_COUNTS)
      * (bdsr_pkg::SETPOINT_MV[bdsr_pkg::LEVEL_8V0] + bdsr_pkg::HEADROOM_MV)
      / bdsr_pkg::MV_UNIT;
   localparam longint unsigned DEN_3 = longint'(ADC_COUNTS)
      * (bdsr_pkg::SETPOINT_MV[bdsr_pkg::LEVEL_11V0] + bdsr_pkg::HEADROOM_MV)
      / bdsr_pkg::MV_UNIT;

   // shift large enough that the rounded-up product is exact for every sample
   localparam int unsigned SHIFT = SAMPLE_W + 1 + $clog2(DEN_3);

   localparam longint unsigned RECIP_0 = (NUM << SHIFT) / DEN_0;
   localparam longint unsigned RECIP_1 = (NUM << SHIFT) / DEN_1;
   localparam longint unsigned RECIP_2 = (NUM << SHIFT) / DEN_2;
   localparam longint unsigned RECIP_3 = (NUM << SHIFT) / DEN_3;

   localparam int unsigned MW   = $clog2(RECIP_0 + 1);
   localparam int unsigned PW   = SAMPLE_W + MW;
   localparam int unsigned CW   = PW + 1 - SHIFT;
   localparam int unsigned CMPW = (CW > DUTY_W + 1) ? CW : DUTY_W + 1;

   localparam logic [PW:0] ROUND_UP = (PW + 1)'((longint'(1) << SHIFT) - 1);

   logic [MW-1:0]   recip;
   logic [PW-1:0]   product;
   logic [PW:0]     rounded;
   logic [CMPW-1:0] quotient;

   always_comb begin
      case (setpoint_level)
         bdsr_pkg::LEVEL_5V0:  recip = MW'(RECIP_0);
         bdsr_pkg::LEVEL_5V5:  recip = MW'(RECIP_1);
         bdsr_pkg::LEVEL_8V0:  recip = MW'(RECIP_2);
         bdsr_pkg::LEVEL_11V0: recip = MW'(RECIP_3);
         default:              recip = MW'(RECIP_0);
      endcase
   end

   assign product  = PW'(vin) * PW'(recip);
   assign rounded  = {1'b0, product} + ROUND_UP;
   assign quotient = CMPW'(rounded[PW:SHIFT]);

   always_comb begin
      if (quotient >= CMPW'(DUTY_STEPS)) begin
         limit = '0;
      end else if (quotient == '0) begin
         limit = DUTY_W'(DUTY_STEPS - 1);
      end else begin
         limit = DUTY_W'(CMPW'(DUTY_STEPS) - quotient);
      end
   end

endmodule

// ===== hw/rtl/bdsr_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdsr_core: one regulation step
// Steps the duty toward the held setpoint, clamps it to the input-voltage
// ceiling, picks the next setpoint and forms the led outputs.
// ----------------------------------------------------------------------------
module bdsr_core #(
   parameter int unsigned ADC_COUNTS = 1024,
   parameter int unsigned DUTY_STEPS = 256,
   localparam int unsigned SAMPLE_W = $clog2(ADC_COUNTS),
   localparam int unsigned DUTY_W   = $clog2(DUTY_STEPS),
   localparam int unsigned BRIGHT_W = SAMPLE_W - 2
) (
   input  logic [DUTY_W-1:0]            duty_level,
   input  bdsr_pkg::setpoint_level_type setpoint_level,
   input  logic [SAMPLE_W-1:0]          vout_sample,
   input  logic [SAMPLE_W-1:0]          vin_sample,
   input  logic [SAMPLE_W-1:0]          request_sample,
   input  logic [SAMPLE_W-1:0]          load_current_sample,
   input  logic [SAMPLE_W-1:0]          request_high_threshold,
   input  logic [SAMPLE_W-1:0]          request_low_threshold,
   output logic [DUTY_W-1:0]            duty_next,
   output bdsr_pkg::setpoint_level_type setpoint_next,
   output logic                         high_voltage_led,
   output logic [BRIGHT_W-1:0]          led_brightness
);

   localparam int unsigned VW = SAMPLE_W + 1;

   // vout * full_scale < setpoint * counts  <=>  vout < ceil(setpoint * counts / full_scale)
   localparam longint unsigned VOUT_LIM_0 =
      (longint'(bdsr_pkg::SETPOINT_MV[bdsr_pkg::LEVEL_5V0]) * ADC_COUNTS
       + bdsr_pkg::FULL_SCALE_MV - 1) / bdsr_pkg::FULL_SCALE_MV;
   localparam longint unsigned VOUT_LIM_1 =
      (longint'(bdsr_pkg::SETPOINT_MV[bdsr_pkg::LEVEL_5V5]) * ADC_COUNTS
       + bdsr_pkg::FULL_SCALE_MV - 1) / bdsr_pkg::FULL_SCALE_MV;
   localparam longint unsigned VOUT_LIM_2 =
      (longint'(bdsr_pkg::SETPOINT_MV[bdsr_pkg::LEVEL_8V0]) * ADC_COUNTS
       + bdsr_pkg::FULL_SCALE_MV - 1) / bdsr_pkg::FULL_SCALE_MV;
   localparam longint unsigned VOUT_LIM_3 =
      (longint'(bdsr_pkg::SETPOINT_MV[bdsr_pkg::LEVEL_11V0]) * ADC_COUNTS
       + bdsr_pkg::FULL_SCALE_MV - 1) / bdsr_pkg::FULL_SCALE_MV;

   logic [VW-1:0]     vout_limit;
   logic              step_up;
   logic [DUTY_W-1:0] duty_stepped;
   logic [DUTY_W-1:0] duty_ceiling;

   always_comb begin
      case (setpoint_level)
         bdsr_pkg::LEVEL_5V0:  vout_limit = VW'(VOUT_LIM_0);
         bdsr_pkg::LEVEL_5V5:  vout_limit = VW'(VOUT_LIM_1);
         bdsr_pkg::LEVEL_8V0:  vout_limit = VW'(VOUT_LIM_2);
         bdsr_pkg::LEVEL_11V0: vout_limit = VW'(VOUT_LIM_3);
         default:              vout_limit = VW'(VOUT_LIM_0);
      endcase
   end

   assign step_up = {1'b0, vout_sample} < vout_limit;

   always_comb begin
      duty_stepped = duty_level;
      if (step_up) begin
         if (duty_level != DUTY_W'(DUTY_STEPS - 1)) begin
            duty_stepped = duty_level + DUTY_W'(1);
         end
      end else if (duty_level != '0) begin
         duty_stepped = duty_level - DUTY_W'(1);
      end
   end

   bdsr_limit #(
      .ADC_COUNTS (ADC_COUNTS),
      .DUTY_STEPS (DUTY_STEPS)
   ) u_limit (
      .vin            (vin_sample),
      .setpoint_level (setpoint_level),
      .limit          (duty_ceiling)
   );

   assign duty_next = (duty_stepped > duty_ceiling) ? duty_ceiling : duty_stepped;

   // high compare wins when the thresholds are crossed over
   always_comb begin
      if (request_sample > request_high_threshold) begin
         setpoint_next = bdsr_pkg::LEVEL_5V5;
      end else if (request_sample > request_low_threshold) begin
         setpoint_next = bdsr_pkg::LEVEL_8V0;
      end else begin
         setpoint_next = bdsr_pkg::LEVEL_11V0;
      end
   end

   assign high_voltage_led = bdsr_pkg::SETPOINT_MV[setpoint_next] > bdsr_pkg::LED_ON_MV;
   assign led_brightness   = load_current_sample[SAMPLE_W-1:2];

endmodule

// ===== hw/rtl/boost_duty_step_regulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boost_duty_step_regulator: boost pwm duty regulator with selectable setpoint
// Takes one word of adc samples per control period and returns the new duty.
// ----------------------------------------------------------------------------
// One sample word in, one result word out. A word is accepted every cycle while
// the result side is not stalled, and it passes through the input register,
// then the result register; the step, the clamp and the setpoint choice
// settle in the single logic stage between them, whose longest path is the
// vin reciprocal multiply of the duty limit. The duty and setpoint state move
// forward as each word passes into the result register, so results come back
// in order and each word sees the setpoint chosen by the word before it. The
// user is to write the two request thresholds on the csr port while no word
// is in flight; the block itself does not enforce this. csr_ready is always
// high and writes to an unknown index are dropped.
module boost_duty_step_regulator #(
   parameter int unsigned ADC_COUNTS = 1024,
   parameter int unsigned DUTY_STEPS = 256,
   localparam int unsigned SAMPLE_W = $clog2(ADC_COUNTS),
   localparam int unsigned DUTY_W   = $clog2(DUTY_STEPS),
   localparam int unsigned BRIGHT_W = SAMPLE_W - 2,
   localparam int unsigned REQ_W    = 8 * ((4 * SAMPLE_W + 7) / 8),
   localparam int unsigned RSP_W    = 8 * ((DUTY_W + 1 + BRIGHT_W + 7) / 8)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // vout_sample, vin_sample, request_sample, load_current_sample
   input  logic [REQ_W-1:0]                   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // duty, high_voltage_led, led_brightness
   output logic [RSP_W-1:0]                   rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bdsr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [SAMPLE_W-1:0]                csr_wdata
);

   logic                         req_fire;
   logic                         advance;

   logic                         in_valid_ff, in_valid_in;
   logic [SAMPLE_W-1:0]          in_vout_ff, in_vout_in;
   logic [SAMPLE_W-1:0]          in_vin_ff, in_vin_in;
   logic [SAMPLE_W-1:0]          in_request_ff, in_request_in;
   logic [SAMPLE_W-1:0]          in_load_ff, in_load_in;

   logic [SAMPLE_W-1:0]          high_th_ff, high_th_in;
   logic [SAMPLE_W-1:0]          low_th_ff, low_th_in;

   logic [DUTY_W-1:0]            duty_ff, duty_in;
   bdsr_pkg::setpoint_level_type level_ff, level_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]            rsp_duty_ff, rsp_duty_in;
   logic                         rsp_led_ff, rsp_led_in;
   logic [BRIGHT_W-1:0]          rsp_bright_ff, rsp_bright_in;

   logic [DUTY_W-1:0]            duty_next;
   bdsr_pkg::setpoint_level_type level_next;
   logic                         led_next;
   logic [BRIGHT_W-1:0]          bright_next;

   // word moves on whenever the result register is free or being drained
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   bdsr_core #(
      .ADC_COUNTS (ADC_COUNTS),
      .DUTY_STEPS (DUTY_STEPS)
   ) u_core (
      .duty_level             (duty_ff),
      .setpoint_level         (level_ff),
      .vout_sample            (in_vout_ff),
      .vin_sample             (in_vin_ff),
      .request_sample         (in_request_ff),
      .load_current_sample    (in_load_ff),
      .request_high_threshold (high_th_ff),
      .request_low_threshold  (low_th_ff),
      .duty_next              (duty_next),
      .setpoint_next          (level_next),
      .high_voltage_led       (led_next),
      .led_brightness         (bright_next)
   );

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_vout_in    = in_vout_ff;
      in_vin_in     = in_vin_ff;
      in_request_in = in_request_ff;
      in_load_in    = in_load_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_fire) begin
         in_valid_in   = 1'b1;
         in_vout_in    = req_tdata[0 +: SAMPLE_W];
         in_vin_in     = req_tdata[SAMPLE_W +: SAMPLE_W];
         in_request_in = req_tdata[2 * SAMPLE_W +: SAMPLE_W];
         in_load_in    = req_tdata[3 * SAMPLE_W +: SAMPLE_W];
      end
   end

   always_comb begin
      high_th_in = high_th_ff;
      low_th_in  = low_th_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            bdsr_pkg::CSR_REQUEST_HIGH: high_th_in = csr_wdata;
            bdsr_pkg::CSR_REQUEST_LOW:  low_th_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      duty_in       = duty_ff;
      level_in      = level_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_duty_in   = rsp_duty_ff;
      rsp_led_in    = rsp_led_ff;
      rsp_bright_in = rsp_bright_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         duty_in       = duty_next;
         level_in      = level_next;
         rsp_valid_in  = 1'b1;
         rsp_duty_in   = duty_next;
         rsp_led_in    = led_next;
         rsp_bright_in = bright_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         duty_ff      <= '0;
         level_ff     <= bdsr_pkg::LEVEL_5V0;
         high_th_ff   <= SAMPLE_W'(bdsr_pkg::REQUEST_HIGH_RESET);
         low_th_ff    <= SAMPLE_W'(bdsr_pkg::REQUEST_LOW_RESET);
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         duty_ff      <= duty_in;
         level_ff     <= level_in;
         high_th_ff   <= high_th_in;
         low_th_ff    <= low_th_in;
      end
   end

   always_ff @(posedge clock) begin
      in_vout_ff    <= in_vout_in;
      in_vin_ff     <= in_vin_in;
      in_request_ff <= in_request_in;
      in_load_ff    <= in_load_in;
      rsp_duty_ff   <= rsp_duty_in;
      rsp_led_ff    <= rsp_led_in;
      rsp_bright_ff <= rsp_bright_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_bright_ff, rsp_led_ff, rsp_duty_ff});

endmodule

// ===== hw/rtl/bdsr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdsr_checker: port-level checks for the boost duty step regulator
// Watches the stream ports of the top level; bound in below.
// ----------------------------------------------------------------------------
module bdsr_checker #(
   parameter int unsigned ADC_COUNTS = 1024,
   parameter int unsigned DUTY_STEPS = 256,
   localparam int unsigned SAMPLE_W = $clog2(ADC_COUNTS),
   localparam int unsigned DUTY_W   = $clog2(DUTY_STEPS),
   localparam int unsigned BRIGHT_W = SAMPLE_W - 2,
   localparam int unsigned REQ_W    = 8 * ((4 * SAMPLE_W + 7) / 8),
   localparam int unsigned RSP_W    = 8 * ((DUTY_W + 1 + BRIGHT_W + 7) / 8)
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [REQ_W-1:0] req_tdata,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   logic              rsp_fire;
   logic              seen_ff, seen_in;
   logic [DUTY_W-1:0] last_duty_ff, last_duty_in;
   logic [DUTY_W:0]   duty_bound;

   assign rsp_fire     = rsp_tvalid && rsp_tready;
   assign seen_in      = seen_ff || rsp_fire;
   assign last_duty_in = rsp_fire ? rsp_tdata[DUTY_W-1:0] : last_duty_ff;
   assign duty_bound   = {1'b0, last_duty_ff} + (DUTY_W + 1)'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      last_duty_ff <= last_duty_in;
   end

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // duty climbs at most one count per delivered word
   a_duty_slew: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && seen_ff |-> {1'b0, rsp_tdata[DUTY_W-1:0]} <= duty_bound)
      else $error("duty rose by more than one count");

   // nothing pending on the result side means the input side is open
   a_req_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with an empty result register");

   // no result straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // an offered and accepted input word with known data implies req_tready
   a_req_fire: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && $isunknown(req_tdata) == 1'b0 |-> req_tready)
      else $error("input handshake inconsistent");

endmodule

bind boost_duty_step_regulator bdsr_checker #(
   .ADC_COUNTS (ADC_COUNTS),
   .DUTY_STEPS (DUTY_STEPS)
) u_bdsr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
